// ----- src/complex_fixed_point_alu_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the complex fixed-point ALU
// Shared property wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIXED_POINT_ALU_TOP_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_TOP_MACROS_SVH

// Plain clocked property with the usual reset qualifier.
`define CFPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// A result that waits on the master side keeps its valid and its payload.
`define CFPA_ASSERT_HOLD(label, sig, msg) \
    `CFPA_ASSERT(label, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(sig)), msg)

`endif

// ----- src/cfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex fixed-point ALU package
// Widths, operation codes, pipeline payload types and clipping helpers.
// ----------------------------------------------------------------------------
package cfpa_pkg;

    localparam int DW    = 32;         // data width of one operand part
    localparam int FB    = 16;         // fraction bits
    localparam int PW    = 32;         // port width of one part
    localparam int KW    = 3;          // width of the operation code
    localparam int PRW   = 2 * DW;     // full product width
    localparam int CW    = 2 * DW + 2; // headroom for sums of products
    localparam int XW    = 3 * DW;     // divider partial remainder width
    localparam int RW    = PRW + 1;    // square root trial width
    localparam int NSTEP = DW;         // quotient and root bits

    typedef enum logic [KW-1:0] {
        K_ADD   = 3'd0,
        K_SUB   = 3'd1,
        K_MUL   = 3'd2,
        K_DIV   = 3'd3,
        K_CONJ  = 3'd4,
        K_MODSQ = 3'd5,
        K_MOD   = 3'd6
    } kind_t;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } clip_t;

    typedef struct packed {
        kind_t                kind;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } op_t;

    typedef struct packed {
        kind_t                 kind;
        logic signed [PRW-1:0] p0;
        logic signed [PRW-1:0] p1;
        logic signed [PRW-1:0] p2;
        logic signed [PRW-1:0] p3;
        logic signed [PRW-1:0] p4;
        logic signed [PRW-1:0] p5;
        logic signed [DW-1:0]  easy_re;
        logic signed [DW-1:0]  easy_im;
        logic                  easy_sat;
    } prod_t;

    typedef struct packed {
        kind_t                kind;
        logic signed [DW-1:0] easy_re;
        logic signed [DW-1:0] easy_im;
        logic                 easy_sat;
        logic signed [CW-1:0] num_re;
        logic signed [CW-1:0] num_im;
        logic [PRW-1:0]       den;
    } front_t;

    typedef struct packed {
        kind_t                kind;
        logic signed [DW-1:0] easy_re;
        logic signed [DW-1:0] easy_im;
        logic                 easy_sat;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [PRW-1:0]       den;
        logic [XW-1:0]        x_re;
        logic [XW-1:0]        x_im;
        logic [DW-1:0]        q_re;
        logic [DW-1:0]        q_im;
        logic [PRW-1:0]       rem;
        logic [DW-1:0]        root;
    } iter_t;

    // Clip a wide signed value to the signed DW range.
    function automatic clip_t clip_wide(input logic signed [CW-1:0] v);
        clip_t                r;
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        hi = (CW'(1) <<< (DW - 1)) - CW'(1);
        lo = -hi - CW'(1);
        r.sat = 1'b0;
        if (v > hi) begin
            r.val = hi[DW-1:0];
            r.sat = 1'b1;
        end else if (v < lo) begin
            r.val = lo[DW-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = v[DW-1:0];
        end
        return r;
    endfunction

    // Clip an unsigned magnitude with a sign; ovf marks a magnitude of 2^DW or more.
    function automatic clip_t pack_mag(input logic [DW-1:0] q, input logic neg,
                                       input logic ovf);
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] big;
        v   = signed'(CW'({1'b0, q}));
        big = CW'(1) <<< DW;
        if (ovf) begin
            v = big;
        end
        return clip_wide(neg ? -v : v);
    endfunction

endpackage

// ----- src/cfpa_front.sv -----
// ----------------------------------------------------------------------------
// Complex ALU front end
// Operand register, six parallel products, and the sums that feed the result
// select, the dividers and the square root.
// ----------------------------------------------------------------------------
module cfpa_front
    import cfpa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kind_t                in_kind,
    input  logic signed [DW-1:0] in_ar,
    input  logic signed [DW-1:0] in_ai,
    input  logic signed [DW-1:0] in_br,
    input  logic signed [DW-1:0] in_bi,
    output logic                 out_valid,
    input  logic                 out_ready,
    output front_t               out_data
);

    logic   v1_reg, v2_reg, v3_reg;
    op_t    op_reg, op_next;
    prod_t  pr_reg, pr_next;
    front_t fr_reg, fr_next;
    logic   ce1, ce2, ce3;

    assign ce3      = !v3_reg || out_ready;
    assign ce2      = !v2_reg || ce3;
    assign ce1      = !v1_reg || ce2;
    assign in_ready = ce1;

    // The squared modulus and the modulus reuse the ar*br and ai*bi products with b taken as a.
    always_comb begin
        op_next.kind = in_kind;
        op_next.ar   = in_ar;
        op_next.ai   = in_ai;
        op_next.br   = in_br;
        op_next.bi   = in_bi;
        if (in_kind == K_MODSQ || in_kind == K_MOD) begin
            op_next.br = in_ar;
            op_next.bi = in_ai;
        end
    end

    always_comb begin
        clip_t c_re, c_im;
        pr_next.kind = op_reg.kind;
        pr_next.p0   = PRW'(op_reg.ar) * PRW'(op_reg.br);
        pr_next.p1   = PRW'(op_reg.ai) * PRW'(op_reg.bi);
        pr_next.p2   = PRW'(op_reg.ar) * PRW'(op_reg.bi);
        pr_next.p3   = PRW'(op_reg.ai) * PRW'(op_reg.br);
        pr_next.p4   = PRW'(op_reg.br) * PRW'(op_reg.br);
        pr_next.p5   = PRW'(op_reg.bi) * PRW'(op_reg.bi);
        unique case (op_reg.kind)
            K_ADD: begin
                c_re = clip_wide(CW'(op_reg.ar) + CW'(op_reg.br));
                c_im = clip_wide(CW'(op_reg.ai) + CW'(op_reg.bi));
            end
            K_SUB: begin
                c_re = clip_wide(CW'(op_reg.ar) - CW'(op_reg.br));
                c_im = clip_wide(CW'(op_reg.ai) - CW'(op_reg.bi));
            end
            K_CONJ: begin
                c_re = clip_wide(CW'(op_reg.ar));
                c_im = clip_wide(-CW'(op_reg.ai));
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        pr_next.easy_re  = c_re.val;
        pr_next.easy_im  = c_im.val;
        pr_next.easy_sat = c_re.sat | c_im.sat;
    end

    always_comb begin
        logic signed [CW-1:0] mre, mim, msq;
        clip_t                c_re, c_im;
        mre = (CW'(pr_reg.p0) - CW'(pr_reg.p1)) >>> FB;
        mim = (CW'(pr_reg.p2) + CW'(pr_reg.p3)) >>> FB;
        msq = (CW'(pr_reg.p0) + CW'(pr_reg.p1)) >>> FB;
        c_re = '0;
        c_im = '0;
        fr_next.kind     = pr_reg.kind;
        fr_next.easy_re  = pr_reg.easy_re;
        fr_next.easy_im  = pr_reg.easy_im;
        fr_next.easy_sat = pr_reg.easy_sat;
        unique case (pr_reg.kind)
            K_MUL: begin
                c_re = clip_wide(mre);
                c_im = clip_wide(mim);
                fr_next.easy_re  = c_re.val;
                fr_next.easy_im  = c_im.val;
                fr_next.easy_sat = c_re.sat | c_im.sat;
            end
            K_MODSQ: begin
                c_re = clip_wide(msq);
                fr_next.easy_re  = c_re.val;
                fr_next.easy_im  = '0;
                fr_next.easy_sat = c_re.sat;
            end
            default: begin
                c_re = '0;
            end
        endcase
        fr_next.num_re = CW'(pr_reg.p0) + CW'(pr_reg.p1);
        fr_next.num_im = CW'(pr_reg.p3) - CW'(pr_reg.p2);
        fr_next.den    = PRW'(pr_reg.p4) + PRW'(pr_reg.p5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ce1) v1_reg <= in_valid;
            if (ce2) v2_reg <= v1_reg;
            if (ce3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce1) op_reg <= op_next;
        if (ce2) pr_reg <= pr_next;
        if (ce3) fr_reg <= fr_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = fr_reg;

endmodule

// ----- src/cfpa_iter.sv -----
// ----------------------------------------------------------------------------
// Complex ALU digit pipeline
// Setup stage, then one quotient bit of both dividers and one root bit of the
// square root per stage.
// ----------------------------------------------------------------------------
module cfpa_iter
    import cfpa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output iter_t  out_data
);

    logic  v_reg [NSTEP+1];
    iter_t d_reg [NSTEP+1];
    wire [NSTEP+1:0] ce;
    iter_t setup_next;

    assign ce[NSTEP+1] = out_ready;
    assign in_ready    = ce[0];

    // Magnitudes, signs and the overflow test: quotient >= 2^DW when
    // mag * 2^FB >= den * 2^DW.
    always_comb begin
        logic [PRW-1:0] mre, mim;
        logic [XW-1:0]  dtop;
        mre  = in_data.num_re < 0 ? PRW'(-in_data.num_re) : PRW'(in_data.num_re);
        mim  = in_data.num_im < 0 ? PRW'(-in_data.num_im) : PRW'(in_data.num_im);
        dtop = XW'(in_data.den) << DW;
        setup_next.kind     = in_data.kind;
        setup_next.easy_re  = in_data.easy_re;
        setup_next.easy_im  = in_data.easy_im;
        setup_next.easy_sat = in_data.easy_sat;
        setup_next.dz       = (in_data.den == '0);
        setup_next.neg_re   = in_data.num_re < 0;
        setup_next.neg_im   = in_data.num_im < 0;
        setup_next.den      = in_data.den;
        setup_next.x_re     = XW'(mre) << FB;
        setup_next.x_im     = XW'(mim) << FB;
        setup_next.ovf_re   = (XW'(mre) << FB) >= dtop;
        setup_next.ovf_im   = (XW'(mim) << FB) >= dtop;
        setup_next.q_re     = '0;
        setup_next.q_im     = '0;
        setup_next.rem      = in_data.num_re[PRW-1:0];
        setup_next.root     = '0;
    end

    assign ce[0] = !v_reg[0] || ce[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce[0]) d_reg[0] <= setup_next;
    end

    for (genvar s = 1; s <= NSTEP; s++) begin : g_step
        localparam int B = NSTEP - s;
        iter_t         nxt;
        logic [XW-1:0] dsh;
        logic [RW-1:0] trial;

        assign ce[s] = !v_reg[s] || ce[s+1];

        always_comb begin
            nxt   = d_reg[s-1];
            dsh   = XW'(d_reg[s-1].den) << B;
            trial = (RW'(d_reg[s-1].root) << (B + 1)) + (RW'(1) << (2 * B));
            if (d_reg[s-1].x_re >= dsh) begin
                nxt.x_re    = d_reg[s-1].x_re - dsh;
                nxt.q_re[B] = 1'b1;
            end
            if (d_reg[s-1].x_im >= dsh) begin
                nxt.x_im    = d_reg[s-1].x_im - dsh;
                nxt.q_im[B] = 1'b1;
            end
            if (RW'(d_reg[s-1].rem) >= trial) begin
                nxt.rem     = d_reg[s-1].rem - trial[PRW-1:0];
                nxt.root[B] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (ce[s]) begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce[s]) d_reg[s] <= nxt;
        end
    end

    assign out_valid = v_reg[NSTEP];
    assign out_data  = d_reg[NSTEP];

endmodule

// ----- src/complex_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// Complex fixed-point ALU, top level
// Streaming signed Q16.16 complex add, subtract, multiply, divide, conjugate,
// squared modulus and modulus.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output side does not stall and
// returns one result item per input item, in order, after three front-end
// stages, one divider setup stage, 32 digit stages and the output register.
// The depth is set by the 32 quotient and root bits, each produced by one stage
// of the digit pipeline; add, subtract, multiply and the other short operations
// travel the same pipeline so that order is kept. Every stage holds its item
// only while the next stage is full and stalled, so empty slots close up and
// the slave side stays ready whenever the output register is
// empty or being taken. Products are exact and shifted down with a floor shift,
// quotients truncate toward zero, the modulus is a floored square root, and any
// part that leaves the signed 32-bit range is clipped with the saturated flag
// set. A divide by zero returns zero with div_by_zero set.
module complex_fixed_point_alu_top
    import cfpa_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // a_re, a_im, b_re, b_im (32 bits each)
    input  logic [KW-1:0] s_tuser,  // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,  // res_re, res_im (32 bits each)
    output logic [1:0]    m_tuser   // saturated, div_by_zero
);

    logic   f_valid, f_ready;
    front_t f_data;
    logic   it_valid, it_ready;
    iter_t  it_data;

    logic                 ov_reg;
    logic signed [DW-1:0] re_reg, re_next;
    logic signed [DW-1:0] im_reg, im_next;
    logic                 sat_reg, sat_next;
    logic                 dz_reg, dz_next;
    logic                 ce_out;

    // Only the low DW bits of each operand part are used.
    cfpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser)),
        .in_ar     (signed'(s_tdata[DW-1:0])),
        .in_ai     (signed'(s_tdata[PW+DW-1:PW])),
        .in_br     (signed'(s_tdata[2*PW+DW-1:2*PW])),
        .in_bi     (signed'(s_tdata[3*PW+DW-1:3*PW])),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    cfpa_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (it_valid),
        .out_ready (it_ready),
        .out_data  (it_data)
    );

    assign ce_out   = !ov_reg || m_tready;
    assign it_ready = ce_out;

    // Final select: divide and modulus come from the digit pipeline, all other
    // kinds were settled in the front end.
    always_comb begin
        clip_t c_re, c_im;
        c_re     = '0;
        c_im     = '0;
        re_next  = it_data.easy_re;
        im_next  = it_data.easy_im;
        sat_next = it_data.easy_sat;
        dz_next  = 1'b0;
        unique case (it_data.kind)
            K_DIV: begin
                if (it_data.dz) begin
                    re_next  = '0;
                    im_next  = '0;
                    sat_next = 1'b0;
                    dz_next  = 1'b1;
                end else begin
                    c_re     = pack_mag(it_data.q_re, it_data.neg_re, it_data.ovf_re);
                    c_im     = pack_mag(it_data.q_im, it_data.neg_im, it_data.ovf_im);
                    re_next  = c_re.val;
                    im_next  = c_im.val;
                    sat_next = c_re.sat | c_im.sat;
                end
            end
            K_MOD: begin
                c_re     = pack_mag(it_data.root, 1'b0, 1'b0);
                re_next  = c_re.val;
                im_next  = '0;
                sat_next = c_re.sat;
            end
            default: begin
                c_re = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (ce_out) begin
            ov_reg <= it_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_out) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            sat_reg <= sat_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {PW'(im_reg), PW'(re_reg)};
    assign m_tuser  = {dz_reg, sat_reg};

endmodule

// ----- src/cfpa_checker.sv -----
// ----------------------------------------------------------------------------
// Complex ALU port checker
// Watches the top-level ports for flow and flag consistency.
// ----------------------------------------------------------------------------
`include "complex_fixed_point_alu_top_macros.svh"

module cfpa_checker
    import cfpa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A waiting result keeps its data and flags.
    `CFPA_ASSERT_HOLD(a_out_hold, {m_tdata, m_tuser}, "result changed while stalled")

    // With the output free to move, every stage can move and the input is ready.
    `CFPA_ASSERT(a_in_ready, (m_tready || !m_tvalid) |-> s_tready,
                 "input stalled needlessly")

    // A divide by zero gives zero and never reports saturation.
    `CFPA_ASSERT(a_dz_zero,
                 (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]),
                 "bad divide by zero result")

    // A saturated result has at least one part at a range limit.
    `CFPA_ASSERT(a_sat_limit,
                 (m_tvalid && m_tuser[0]) |->
                     (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
                      m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000),
                 "saturated without a clipped part")

endmodule

bind complex_fixed_point_alu_top cfpa_checker u_cfpa_checker (.*);

// ----- tb/sv/tb_complex_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the complex fixed-point ALU
// Drives directed and random operand items through the streaming input with
// random gaps, stalls the result side at random, and compares every result
// item with an independent prediction of the Q16.16 arithmetic.
// ----------------------------------------------------------------------------
module tb_complex_fixed_point_alu_top;
    import cfpa_pkg::*;

    localparam int  RANDOM_ITEMS = 1750;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  FULL         = 130;   // wide enough for any exact sum of products
    localparam logic [2:0] K_UNUSED = 3'd7;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        sat;
        logic        dz;
    } cplx_result_t;

    // Holds the predicted results in acceptance order and checks each result
    // item against the oldest one.
    class cplx_result_book;
        cplx_result_t pending_results[$];
        int           mismatches;

        // Clip an exact value to the signed 32-bit range, noting any clipping.
        function automatic logic [31:0] clip32(input logic signed [FULL-1:0] v,
                                               inout logic sat);
            logic signed [FULL-1:0] hi;
            logic signed [FULL-1:0] lo;
            hi = (FULL'(1) <<< 31) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                sat = 1'b1;
                return hi[31:0];
            end else if (v < lo) begin
                sat = 1'b1;
                return lo[31:0];
            end
            return v[31:0];
        endfunction

        // Floored integer square root of a 64-bit value, one bit at a time.
        function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
            logic [63:0]  root;
            logic [127:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = 128'(root | (64'd1 << b));
                if (trial * trial <= 128'(n)) root = trial[63:0];
            end
            return root;
        endfunction

        function automatic cplx_result_t predict_cplx(input logic [2:0] kind,
                input logic signed [31:0] ar, input logic signed [31:0] ai,
                input logic signed [31:0] br, input logic signed [31:0] bi);
            cplx_result_t           r;
            logic signed [FULL-1:0] xr, xi, yr, yi, num, den, mag, q;
            r  = '{re: '0, im: '0, sat: 1'b0, dz: 1'b0};
            xr = ar;
            xi = ai;
            yr = br;
            yi = bi;
            case (kind)
                K_ADD: begin
                    r.re = clip32(xr + yr, r.sat);
                    r.im = clip32(xi + yi, r.sat);
                end
                K_SUB: begin
                    r.re = clip32(xr - yr, r.sat);
                    r.im = clip32(xi - yi, r.sat);
                end
                K_MUL: begin
                    // Arithmetic shift of the exact value is a floor division.
                    r.re = clip32((xr * yr - xi * yi) >>> FB, r.sat);
                    r.im = clip32((xr * yi + xi * yr) >>> FB, r.sat);
                end
                K_DIV: begin
                    den = yr * yr + yi * yi;
                    if (den == 0) begin
                        r.dz = 1'b1;
                    end else begin
                        // Quotient magnitude truncates, so the sign goes on last.
                        num  = xr * yr + xi * yi;
                        mag  = (num < 0) ? -num : num;
                        q    = (mag <<< FB) / den;
                        r.re = clip32((num < 0) ? -q : q, r.sat);
                        num  = xi * yr - xr * yi;
                        mag  = (num < 0) ? -num : num;
                        q    = (mag <<< FB) / den;
                        r.im = clip32((num < 0) ? -q : q, r.sat);
                    end
                end
                K_CONJ: begin
                    r.re = clip32(xr, r.sat);
                    r.im = clip32(-xi, r.sat);
                end
                K_MODSQ: begin
                    r.re = clip32((xr * xr + xi * xi) >>> FB, r.sat);
                end
                K_MOD: begin
                    num  = xr * xr + xi * xi;
                    q    = FULL'(floor_sqrt(num[63:0]));
                    r.re = clip32(q, r.sat);
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_operands(input logic [2:0] kind, input logic [127:0] ops);
            pending_results.push_back(predict_cplx(kind, ops[31:0], ops[63:32],
                                                   ops[95:64], ops[127:96]));
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            mismatches++;
            $display("mismatch in %s: got %h, expected %h", what, got, want);
        endtask

        task check_result(input logic [63:0] data, input logic [1:0] flags);
            cplx_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", data[31:0], 32'h0);
                return;
            end
            want = pending_results.pop_front();
            if (data[31:0] !== want.re) report_mismatch("res_re", data[31:0], want.re);
            if (data[63:32] !== want.im) report_mismatch("res_im", data[63:32], want.im);
            if (flags[0] !== want.sat) begin
                report_mismatch("saturated", 32'(flags[0]), 32'(want.sat));
            end
            if (flags[1] !== want.dz) begin
                report_mismatch("div_by_zero", 32'(flags[1]), 32'(want.dz));
            end
        endtask
    endclass

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [KW-1:0] s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    cplx_result_book book = new();
    bit          calm;          // when set, neither side inserts idle cycles
    int          stall_left;
    int unsigned cycles;

    complex_fixed_point_alu_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The watchdog ends a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Every accepted input item gets its prediction at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) book.note_operands(s_tuser, s_tdata);
    end

    // The result side stalls in short and long bursts and checks each item it
    // takes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata, m_tuser);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(10, 45);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One operand part: some full-range, some extremes, mostly small values
    // that keep products inside the range.
    function automatic logic [31:0] pick_part();
        logic [31:0] corner[8];
        int          r;
        corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom();
        if (r < 50) return corner[$urandom_range(0, 7)];
        return 32'(signed'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    // Present one item after a random gap and hold it until it is taken.
    task send_item(input logic [2:0] kind, input logic [31:0] ar, input logic [31:0] ai,
                   input logic [31:0] br, input logic [31:0] bi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {bi, br, ai, ar};
        do @(posedge aclk); while (!s_tready);
    endtask

    // One edge first, so the item taken at the last edge is already booked.
    task wait_drained();
        @(posedge aclk);
        while (book.pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] bp;
        logic [2:0]  k;
        calm = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items: every operation, the range limits and each special case.
        send_item(K_ADD,   32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
        send_item(K_ADD,   32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0000_8000);
        send_item(K_SUB,   32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        send_item(K_SUB,   32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
        send_item(K_MUL,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(K_MUL,   32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_item(K_MUL,   32'h0002_0000, 32'h0001_8000, 32'hffff_0000, 32'h0000_4000);
        // Divide by zero, with nonzero numerator and with everything zero.
        send_item(K_DIV,   32'h1234_5678, 32'h8000_0000, 32'h0,         32'h0);
        send_item(K_DIV,   32'h0,         32'h0,         32'h0,         32'h0);
        send_item(K_DIV,   32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
        send_item(K_DIV,   32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
        send_item(K_DIV,   32'hffff_ffff, 32'h0,         32'h7fff_ffff, 32'h8000_0000);
        // Conjugate of the most negative imaginary part clips.
        send_item(K_CONJ,  32'h8000_0000, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa);
        send_item(K_CONJ,  32'h0001_0000, 32'hfffe_0000, 32'h0,         32'h0);
        send_item(K_MODSQ, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(K_MODSQ, 32'h0003_0000, 32'hfffc_0000, 32'h0,         32'h0);
        send_item(K_MOD,   32'h8000_0000, 32'h8000_0000, 32'h0,         32'h0);
        send_item(K_MOD,   32'h0003_0000, 32'h0004_0000, 32'h1,         32'h1);
        send_item(K_MOD,   32'h0,         32'h0,         32'h0,         32'h0);
        send_item(K_MOD,   32'h7fff_ffff, 32'h0,         32'h0,         32'h0);
        // The unused code returns zeros with both flags clear.
        send_item(K_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        // The sender holds off until the pipeline has emptied completely.
        s_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Every 250 items, sometimes run a stretch with no idling at all.
            if (i % 250 == 0) calm = ($urandom_range(0, 2) == 0);
            k  = (i % 97 == 96) ? K_UNUSED : 3'($urandom_range(0, 6));
            bp = pick_part();
            send_item(k, pick_part(), pick_part(), bp,
                      ($urandom_range(0, 19) == 0) ? 32'h0 : pick_part());
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.mismatches == 0 && book.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
